### design/urnp_pkg.sv
// ----------------------------------------------------------------------------
// urnp_pkg
// Shared types, codes and character helpers for the UDP receive notice parser.
// ----------------------------------------------------------------------------
`default_nettype none

package urnp_pkg;

	// sizes
	localparam int LINE_LENGTH_DEF = 64;
	localparam int TIMEOUT_W       = 15;
	localparam int MAX_LEN_W       = 16;
	localparam int CHAR_CNT_W      = 17;
	localparam int HEAD_CNT_W      = 4;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;

	// register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd1;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 15'd1000;
	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = 16'd1024;

	// item operations
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_CHAR  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_FMT  = 2'd2;
	localparam logic [1:0] KIND_TIME = 2'd3;

	// header lengths
	localparam logic [HEAD_CNT_W-1:0] HEAD_TOTAL = 4'd9;
	localparam logic [HEAD_CNT_W-1:0] HEAD_CMP   = 4'd8;

	// special characters
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEAD,
		PH_SOCK,
		PH_IP,
		PH_PORT,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_count;
	} result_t;

	// expected header text "+MIPRUDP"
	function automatic logic [7:0] head_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h2B;
			3'd1: c = 8'h4D;
			3'd2: c = 8'h49;
			3'd3: c = 8'h50;
			3'd4: c = 8'h52;
			3'd5: c = 8'h55;
			3'd6: c = 8'h44;
			3'd7: c = 8'h50;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// hex digit value, bit 4 flags a valid digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) v = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46) v = {1'b1, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66) v = {1'b1, 4'(c - 8'h57)};
		return v;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	// two-character decode, lenient like a two-digit hex scan
	function automatic logic [7:0] decode_pair(input logic [7:0] c0, input logic [7:0] c1);
		logic [4:0] h;
		logic [4:0] l;
		logic [7:0] b;
		h = hex_val(c0);
		l = hex_val(c1);
		if (!h[4]) b = 8'h00;
		else if (!l[4]) b = {4'h0, h[3:0]};
		else b = {h[3:0], l[3:0]};
		return b;
	endfunction

endpackage

`default_nettype wire

### design/udp_receive_notice_parser_core.sv
// ----------------------------------------------------------------------------
// udp_receive_notice_parser_core
// Parses modem UDP receive notices from a character stream into payload bytes.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_stall      item_t   {op, ch}
//  result    out        result_valid / result_stall  result_t {kind, data_byte, byte_count}
//  cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
//  One item per cycle unless item_stall holds the flow; an item passes through
//  the input register, then the result register, before its result appears.
//  The parser state updates once for each item that it takes.
//  A stalled result holds the input register; item_stall rises only when both
//  registers are full. cfg_ready is always high.
//  Reset clears the parser to idle and loads the register reset values.
//
`default_nettype none

module udp_receive_notice_parser_core
	import urnp_pkg::*;
#(
	parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire item_t                 item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [TIMEOUT_W-1:0] timeout_ticks_q;
	logic [MAX_LEN_W-1:0] max_len_q;
	logic                 room;
	logic                 fire;
	item_t                item_s1;
	logic                 emit;
	result_t              res;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= TIMEOUT_RST;
			max_len_q       <= MAX_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TIMEOUT: timeout_ticks_q <= cfg_data[TIMEOUT_W-1:0];
				REG_MAX_LEN: max_len_q       <= cfg_data[MAX_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	urnp_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (item_valid),
		.stall   (item_stall),
		.item    (item),
		.room    (room),
		.fire    (fire),
		.item_s1 (item_s1)
	);

	// parser
	urnp_parser #(
		.LINE_LENGTH (LINE_LENGTH)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.item_s1       (item_s1),
		.timeout_ticks (timeout_ticks_q),
		.max_len       (max_len_q),
		.emit          (emit),
		.res           (res)
	);

	// result register
	urnp_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit),
		.res    (res),
		.room   (room),
		.valid  (result_valid),
		.stall  (result_stall),
		.result (result)
	);

endmodule

`default_nettype wire

### design/urnp_in_stage.sv
// ----------------------------------------------------------------------------
// urnp_in_stage
// Input register: holds one item until the parser can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module urnp_in_stage
	import urnp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  valid,
	output logic       stall,
	input  wire item_t item,
	input  wire logic  room,
	output logic       fire,
	output item_t      item_s1
);

	logic valid_s1;

	// item in the register moves on when the result side has room
	assign fire  = valid_s1 && room;
	assign stall = valid_s1 && !room;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (valid && !stall) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

### design/urnp_parser.sv
// ----------------------------------------------------------------------------
// urnp_parser
// Notice state machine: header hunt, field skip, pair decode and timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module urnp_parser
	import urnp_pkg::*;
#(
	parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fire,
	input  wire item_t                item_s1,
	input  wire logic [TIMEOUT_W-1:0] timeout_ticks,
	input  wire logic [MAX_LEN_W-1:0] max_len,
	output logic                      emit,
	output result_t                   res
);

	localparam int FC_W = $clog2(LINE_LENGTH);
	localparam logic [FC_W-1:0] FC_LIMIT = FC_W'(LINE_LENGTH - 1);

	phase_t                  phase_q, phase_d;
	logic [HEAD_CNT_W-1:0]   hc_q, hc_d;
	logic                    match_q, match_d;
	logic [FC_W-1:0]         fc_q, fc_d;
	logic [7:0]              high_q, high_d;
	logic [CHAR_CNT_W-1:0]   cc_q, cc_d;
	logic [TIMEOUT_W-1:0]    ticks_q, ticks_d;

	logic [7:0]              ch;
	logic                    hd_take;
	logic                    hd_miss;
	logic [HEAD_CNT_W-1:0]   hd_cnt;
	logic                    hd_match;
	logic [FC_W-1:0]         fld_cnt;
	logic                    fld_bad;
	logic [MAX_LEN_W-1:0]    pair_idx;
	logic [CHAR_CNT_W-1:0]   cc_inc;
	logic [MAX_LEN_W-1:0]    done_n;
	logic [TIMEOUT_W-1:0]    tick_dec;

	assign ch = item_s1.ch;

	// header hunt step
	assign hd_take  = (ch == CH_PLUS) || (hc_q != '0);
	assign hd_miss  = hd_take && (hc_q < HEAD_CMP) && (ch != head_char(hc_q[2:0]));
	assign hd_cnt   = hd_take ? hc_q + 1'b1 : hc_q;
	assign hd_match = hd_miss ? 1'b0 : match_q;

	// field length and fault check
	assign fld_cnt = fc_q + 1'b1;
	assign fld_bad = (ch == CH_CR) || (ch == CH_LF) || (ch == CH_NUL) || (fld_cnt >= FC_LIMIT);

	// payload counters
	assign pair_idx = cc_q[CHAR_CNT_W-1:1];
	assign cc_inc   = (cc_q != '1) ? cc_q + 1'b1 : cc_q;
	assign done_n   = (pair_idx > max_len) ? max_len : pair_idx;
	assign tick_dec = (ticks_q != '0) ? ticks_q - 1'b1 : ticks_q;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hc_q    <= '0;
			match_q <= 1'b1;
			fc_q    <= '0;
			high_q  <= '0;
			cc_q    <= '0;
			ticks_q <= '0;
		end else begin
			phase_q <= phase_d;
			hc_q    <= hc_d;
			match_q <= match_d;
			fc_q    <= fc_d;
			high_q  <= high_d;
			cc_q    <= cc_d;
			ticks_q <= ticks_d;
		end
	end

	// next state and result
	always_comb begin
		phase_d = phase_q;
		hc_d    = hc_q;
		match_d = match_q;
		fc_d    = fc_q;
		high_d  = high_q;
		cc_d    = cc_q;
		ticks_d = ticks_q;
		emit    = 1'b0;
		res     = '0;
		if (fire) begin
			unique case (item_s1.op)
				OP_START: begin
					hc_d    = '0;
					match_d = 1'b1;
					fc_d    = '0;
					high_d  = '0;
					cc_d    = '0;
					ticks_d = timeout_ticks;
					if (timeout_ticks == '0) begin
						phase_d  = PH_IDLE;
						emit     = 1'b1;
						res.kind = KIND_TIME;
					end else begin
						phase_d = PH_HEAD;
					end
				end
				OP_CHAR: begin
					unique case (phase_q)
						PH_HEAD: begin
							if (hd_cnt >= HEAD_TOTAL) begin
								if (hd_match) begin
									phase_d = PH_SOCK;
									fc_d    = '0;
								end
								hc_d    = '0;
								match_d = 1'b1;
							end else begin
								hc_d    = hd_cnt;
								match_d = hd_match;
							end
						end
						PH_SOCK, PH_IP, PH_PORT: begin
							if (ch == CH_COMMA) begin
								phase_d = (phase_q == PH_SOCK) ? PH_IP :
									(phase_q == PH_IP) ? PH_PORT : PH_DATA;
								fc_d    = '0;
								high_d  = '0;
								cc_d    = '0;
							end else if (fld_bad) begin
								phase_d  = PH_IDLE;
								fc_d     = '0;
								emit     = 1'b1;
								res.kind = KIND_FMT;
							end else begin
								fc_d = fld_cnt;
							end
						end
						PH_DATA: begin
							if (is_alnum(ch)) begin
								if (!cc_q[0]) begin
									high_d = ch;
								end else if (pair_idx < max_len) begin
									emit           = 1'b1;
									res.kind       = KIND_BYTE;
									res.data_byte  = decode_pair(high_q, ch);
									res.byte_count = pair_idx;
								end
								cc_d = cc_inc;
							end else begin
								phase_d        = PH_IDLE;
								emit           = 1'b1;
								res.kind       = KIND_DONE;
								res.byte_count = done_n;
							end
						end
						default: ;
					endcase
				end
				OP_TICK: begin
					if (phase_q != PH_IDLE) begin
						ticks_d = tick_dec;
						if (tick_dec == '0) begin
							phase_d  = PH_IDLE;
							emit     = 1'b1;
							res.kind = KIND_TIME;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/urnp_out_stage.sv
// ----------------------------------------------------------------------------
// urnp_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module urnp_out_stage
	import urnp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res,
	output logic         room,
	output logic         valid,
	input  wire logic    stall,
	output result_t      result
);

	logic valid_q;

	// free when empty or being taken this cycle
	assign room  = !valid_q || !stall;
	assign valid = valid_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (room && load) begin
			result <= res;
		end
	end

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the UDP receive notice parser item by item against a behavioral
// tracker of its own. A directed notice comes first, then random notices
// (mostly well formed, some with broken headers, faulty or overlong fields,
// idle ticks and restarts) under several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import urnp_pkg::*;

	// op code the block leaves unused
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int CHAR_CNT_MAX = (1 << CHAR_CNT_W) - 1;

	// tracks parser state and holds the results owed by the block
	class notice_tracker;
		result_t     due_results[$];
		int          mismatch_count;
		int unsigned timeout_ticks;
		int unsigned max_len;
		int unsigned ticks_left;
		int unsigned char_count;
		int unsigned field_count;
		int unsigned header_count;
		bit          header_match;
		logic [7:0]  first_char;
		phase_t      phase;
		string       marker;

		function new();
			timeout_ticks = TIMEOUT_RST;
			max_len = MAX_LEN_RST;
			ticks_left = 0;
			char_count = 0;
			field_count = 0;
			header_count = 0;
			header_match = 1'b1;
			first_char = 8'h00;
			phase = PH_IDLE;
			marker = "+MIPRUDP";
			mismatch_count = 0;
		endfunction

		static function bit word_char(logic [7:0] c);
			return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		endfunction

		// value of a hex digit, -1 for anything else
		static function int nibble(logic [7:0] c);
			if (c >= "0" && c <= "9") return c - "0";
			if (c >= "A" && c <= "F") return c - "A" + 10;
			if (c >= "a" && c <= "f") return c - "a" + 10;
			return -1;
		endfunction

		// lenient two-digit scan: stops at the first non-digit
		static function logic [7:0] pair_value(logic [7:0] c0, logic [7:0] c1);
			int h;
			int l;
			h = nibble(c0);
			l = nibble(c1);
			if (h < 0) return 8'h00;
			if (l < 0) return 8'(h);
			return 8'(h * 16 + l);
		endfunction

		function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_TIMEOUT) timeout_ticks = data[TIMEOUT_W-1:0];
			else if (idx == REG_MAX_LEN) max_len = data[MAX_LEN_W-1:0];
		endfunction

		function void owe(logic [1:0] kind, logic [7:0] data, logic [15:0] count);
			result_t r;
			r.kind = kind;
			r.data_byte = data;
			r.byte_count = count;
			due_results.push_back(r);
		endfunction

		function void take_char(logic [7:0] c);
			int unsigned n;
			case (phase)
				PH_HEAD: begin
					if (c == CH_PLUS || header_count != 0) begin
						if (header_count < HEAD_CMP && c != marker[header_count])
							header_match = 1'b0;
						header_count++;
					end
					if (header_count >= HEAD_TOTAL) begin
						if (header_match) begin
							phase = PH_SOCK;
							field_count = 0;
						end
						header_count = 0;
						header_match = 1'b1;
					end
				end
				PH_SOCK, PH_IP, PH_PORT: begin
					field_count++;
					if (c == CH_COMMA) begin
						phase = (phase == PH_PORT) ? PH_DATA : phase_t'(phase + 1);
						field_count = 0;
						first_char = 8'h00;
						char_count = 0;
					end else if (c == CH_CR || c == CH_LF || c == CH_NUL ||
						field_count >= LINE_LENGTH_DEF - 1) begin
						phase = PH_IDLE;
						field_count = 0;
						owe(KIND_FMT, 8'h00, 16'h0000);
					end
				end
				PH_DATA: begin
					if (word_char(c)) begin
						if (char_count[0] == 1'b0) begin
							first_char = c;
						end else begin
							n = char_count >> 1;
							if (n < max_len) owe(KIND_BYTE, pair_value(first_char, c), 16'(n));
						end
						if (char_count < CHAR_CNT_MAX) char_count++;
					end else begin
						n = char_count >> 1;
						if (n > max_len) n = max_len;
						phase = PH_IDLE;
						owe(KIND_DONE, 8'h00, 16'(n));
					end
				end
				default: ;
			endcase
		endfunction

		// returns 1 when the item does anything at all
		function bit take_item(item_t it);
			bit worked;
			worked = (it.op == OP_START) ||
				(phase != PH_IDLE && (it.op == OP_CHAR || it.op == OP_TICK));
			if (it.op == OP_START) begin
				header_count = 0;
				header_match = 1'b1;
				field_count = 0;
				first_char = 8'h00;
				char_count = 0;
				ticks_left = timeout_ticks;
				if (ticks_left == 0) begin
					phase = PH_IDLE;
					owe(KIND_TIME, 8'h00, 16'h0000);
				end else begin
					phase = PH_HEAD;
				end
			end else if (phase != PH_IDLE) begin
				if (it.op == OP_CHAR) begin
					take_char(it.ch);
				end else if (it.op == OP_TICK) begin
					if (ticks_left > 0) ticks_left--;
					if (ticks_left == 0) begin
						phase = PH_IDLE;
						owe(KIND_TIME, 8'h00, 16'h0000);
					end
				end
			end
			return worked;
		endfunction

		function void complain(string what, int want, int got);
			mismatch_count++;
			if (mismatch_count <= 200) $error("%s: expected %0d, got %0d", what, want, got);
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 200)
					$error("unexpected result: kind %0d, data_byte %0d, byte_count %0d",
						got.kind, got.data_byte, got.byte_count);
				return;
			end
			want = due_results.pop_front();
			if (got.kind !== want.kind) complain("kind", want.kind, got.kind);
			if (got.data_byte !== want.data_byte) complain("data_byte", want.data_byte, got.data_byte);
			if (got.byte_count !== want.byte_count)
				complain("byte_count", want.byte_count, got.byte_count);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	item_t                 item_word = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result_word;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	notice_tracker trk = new();
	item_t         notice_items[$];
	int            worked_items = 0;
	int            burst_left = 0;
	int            stall_cycle = 0;
	int            stall_mode = 0;

	udp_receive_notice_parser_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_word),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	initial begin
		#8000000;
		$display("Mismatches found");
		$finish;
	end

	// receiver stall pattern, switching between randomly chosen modes
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 1;
		if (stall_cycle % 97 == 0) stall_mode <= $urandom_range(0, 3);
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= 1'($urandom_range(0, 1));
				2: result_stall <= (stall_cycle % 7) < 3;
				default: result_stall <= $urandom_range(0, 9) < 8;
			endcase
		end
	end

	// watch both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall && trk.take_item(item_word)) worked_items++;
			if (result_valid && !result_stall) trk.match_result(result_word);
		end
	end

	function automatic void add_op(logic [1:0] op, logic [7:0] ch);
		item_t it;
		it.op = op;
		it.ch = ch;
		notice_items.push_back(it);
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) add_op(OP_CHAR, s[i]);
	endfunction

	// character with occasional idle tick, unused op or restart ahead of it
	function automatic void add_char(logic [7:0] c);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5) add_op(OP_TICK, 8'($urandom));
		else if (roll == 5) add_op(OP_NONE, 8'($urandom));
		else if (roll == 6) add_op(OP_START, 8'($urandom));
		add_op(OP_CHAR, c);
	endfunction

	function automatic logic [7:0] other_char();
		logic [7:0] c;
		do c = 8'($urandom); while (notice_tracker::word_char(c));
		return c;
	endfunction

	function automatic logic [7:0] data_char();
		string hex;
		hex = "0123456789abcdefABCDEF";
		if ($urandom_range(0, 99) < 85) return hex[$urandom_range(0, 21)];
		if ($urandom_range(0, 1) == 0) return 8'("g" + $urandom_range(0, 19));
		return 8'("G" + $urandom_range(0, 19));
	endfunction

	function automatic logic [7:0] field_char();
		logic [7:0] c;
		if ($urandom_range(0, 9) != 0) return ($urandom_range(0, 4) == 0) ? "." :
			8'("0" + $urandom_range(0, 9));
		do c = 8'($urandom); while (c == CH_COMMA || c == CH_CR || c == CH_LF || c == CH_NUL);
		return c;
	endfunction

	// one notice: start, noise, header, three fields, payload, terminator
	function automatic void build_notice();
		string head;
		logic [7:0] c;
		int bad;
		int n;
		int k;
		notice_items.delete();
		head = "+MIPRUDP=";
		if ($urandom_range(0, 9) != 0) add_op(OP_START, 8'($urandom));
		if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) add_char(8'($urandom));
		bad = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 8) : -1;
		for (int i = 0; i < 9; i++) begin
			c = head[i];
			if (i == bad || (i == 8 && $urandom_range(0, 4) == 0)) c = 8'($urandom);
			add_char(c);
		end
		for (int f = 0; f < 3; f++) begin
			k = $urandom_range(0, 99);
			n = (k < 4) ? $urandom_range(60, 66) : $urandom_range(0, 5);
			for (int i = 0; i < n; i++) add_char(field_char());
			if (k >= 4 && k < 10) begin
				case ($urandom_range(0, 2))
					0: add_char(CH_CR);
					1: add_char(CH_LF);
					default: add_char(CH_NUL);
				endcase
			end
			add_char(CH_COMMA);
		end
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
		for (int i = 0; i < n; i++) add_char(data_char());
		add_char(other_char());
	endfunction

	// offer one item, with bursts and gaps on the sending side
	task automatic send_item(input item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		item_word <= it;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic send_notice_items();
		foreach (notice_items[i]) send_item(notice_items[i]);
	endtask

	// drain: nothing owed, then time for items with no result to pass
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (trk.due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] tmo, input logic [15:0] mlen);
		cfg_valid <= 1'b1;
		cfg_index <= REG_TIMEOUT;
		cfg_data <= tmo;
		do @(posedge clk); while (!cfg_ready);
		trk.load_reg(REG_TIMEOUT, tmo);
		cfg_index <= REG_MAX_LEN;
		cfg_data <= mlen;
		do @(posedge clk); while (!cfg_ready);
		trk.load_reg(REG_MAX_LEN, mlen);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [15:0] tmo, input logic [15:0] mlen, input int target);
		set_regs(tmo, mlen);
		worked_items = 0;
		while (worked_items < target) begin
			build_notice();
			send_notice_items();
		end
		settle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle block ignores items, then one notice with every pair decode case
		notice_items.delete();
		add_op(OP_NONE, 8'hFF);
		add_op(OP_CHAR, 8'h00);
		add_op(OP_TICK, 8'h5A);
		add_op(OP_START, 8'h00);
		add_text("+MIPRUDP=,,,fFG11Gz");
		add_op(OP_CHAR, 8'hFF);
		send_notice_items();
		settle();

		// random notices under several settings
		run_phase(16'd1000, 16'd1024, 300);
		run_phase(16'd12, 16'd4, 350);
		run_phase(16'd0, 16'd0, 40);
		run_phase(16'hFFFF, 16'hFFFF, 300);
		run_phase(16'($urandom_range(1, 50)), 16'($urandom_range(0, 16)), 350);
		run_phase(16'd3, 16'd1, 250);
		run_phase(16'($urandom), 16'($urandom), 310);

		if (trk.mismatch_count == 0 && trk.due_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
